// File: sv/dkuc_pkg.sv
// Shared types, codes and letter tables of the dead key umlaut composer
`timescale 1ns / 1ps

package dkuc_pkg;

  // input command codes
  localparam logic [1:0] CMD_CHAR = 2'd0;
  localparam logic [1:0] CMD_BKSP = 2'd1;

  // result item kinds
  localparam logic [1:0] KIND_ERASE = 2'd0;
  localparam logic [1:0] KIND_EMIT  = 2'd1;
  localparam logic [1:0] KIND_NONE  = 2'd2;

  localparam logic [15:0] APOSTROPHE = 16'h0027;

  localparam int TDATA_W = 24;

  // classified key event
  typedef enum logic [1:0] {
    OP_CHAR,
    OP_BKSP,
    OP_BREAK
  } op_kind_t;

  typedef struct packed {
    op_kind_t    kind;
    logic [15:0] ch;
    logic        is_letter;
    logic        is_apos;
    logic [15:0] acute;
  } op_t;

  // special letter of a rule letter, zero when the letter has no rule
  typedef struct packed {
    logic [15:0] sp;
    logic        trig3;
  } rule_t;

  function automatic rule_t letter_rule(input logic [15:0] c);
    rule_t r;
    r = '0;
    case (c)
      16'h0061: r.sp = 16'h00E4;
      16'h0041: r.sp = 16'h00C4;
      16'h0075: r.sp = 16'h00FC;
      16'h0055: r.sp = 16'h00DC;
      16'h006F: r.sp = 16'h00F6;
      16'h004F: r.sp = 16'h00D6;
      16'h0073, 16'h0053: begin
        r.sp    = 16'h00DF;
        r.trig3 = 1'b1;
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] acute_of(input logic [15:0] c);
    logic [15:0] a;
    case (c)
      16'h0065: a = 16'h00E9;
      16'h0045: a = 16'h00C9;
      16'h0061: a = 16'h00E1;
      16'h0041: a = 16'h00C1;
      16'h0069: a = 16'h00ED;
      16'h0049: a = 16'h00CD;
      16'h006F: a = 16'h00F3;
      16'h004F: a = 16'h00D3;
      16'h0075: a = 16'h00FA;
      16'h0055: a = 16'h00DA;
      16'h0079: a = 16'h00FD;
      16'h0059: a = 16'h00DD;
      default:  a = 16'h0000;
    endcase
    return a;
  endfunction

  function automatic logic is_letter(input logic [15:0] c);
    return ((c >= 16'h0061) && (c <= 16'h007A)) || ((c >= 16'h0041) && (c <= 16'h005A));
  endfunction

endpackage

// File: sv/dead_key_umlaut_composer.sv
// Dead key umlaut composer: per key event, rebuilds the word and emits edit items
// Per key: the event passes the queue; backspace strips the trailing letter or run,
//   the typed letters are rebuilt run by run into the new text, the common prefix
//   with the shown text is found, then the result items are sent.
// Throughput: one key event at a time through the back end sequencer; a two entry
//   queue lets the next events be accepted meanwhile.
// Reset clears counts, dead key flag, queue and output; word buffers are not cleared.
`timescale 1ns / 1ps

module dead_key_umlaut_composer #(
  parameter int BUFFER_DEPTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [dkuc_pkg::TDATA_W-1:0] s_tdata,  // cmd[1:0], key_char[17:2], zero pad
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [dkuc_pkg::TDATA_W-1:0] m_tdata,  // kind[1:0], code[17:2], zero pad
  output logic                         m_tlast,
  output logic                         m_tuser   // handled
);

  logic          op_valid;
  logic          op_ready;
  dkuc_pkg::op_t op;

  dkuc_front u_front (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .op_valid(op_valid), .op_ready(op_ready), .op(op)
  );

  dkuc_back #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_back (
    .clk(clk), .rst(rst), .op_valid(op_valid), .op_ready(op_ready), .op(op),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tlast(m_tlast), .m_tuser(m_tuser)
  );

endmodule

// File: sv/dkuc_ram.sv
// Generic single write port RAM with registered read
`timescale 1ns / 1ps

module dkuc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/dkuc_front.sv
// Front end: accepts key events, classifies them and queues them
`timescale 1ns / 1ps

module dkuc_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [dkuc_pkg::TDATA_W-1:0] s_tdata,  // cmd[1:0], key_char[17:2], zero pad
  output logic                         op_valid,
  input  logic                         op_ready,
  output dkuc_pkg::op_t                op
);

  dkuc_pkg::op_t dec;
  dkuc_pkg::op_t q [2];
  logic          wptr;
  logic          rptr;
  logic [1:0]    cnt;
  logic          push;
  logic          pop;
  logic [1:0]    cmd;
  logic [15:0]   ch;

  // decode the incoming event
  always_comb begin
    cmd           = s_tdata[1:0];
    ch            = s_tdata[17:2];
    dec.ch        = ch;
    dec.is_letter = dkuc_pkg::is_letter(ch);
    dec.is_apos   = (ch == dkuc_pkg::APOSTROPHE);
    dec.acute     = dkuc_pkg::acute_of(ch);
    if (cmd == dkuc_pkg::CMD_CHAR) begin
      dec.kind = dkuc_pkg::OP_CHAR;
    end else if (cmd == dkuc_pkg::CMD_BKSP) begin
      dec.kind = dkuc_pkg::OP_BKSP;
    end else begin
      dec.kind = dkuc_pkg::OP_BREAK;
    end
  end

  assign s_tready = (cnt != 2'd2);
  assign push     = s_tvalid && s_tready;
  assign op_valid = (cnt != 2'd0);
  assign pop      = op_valid && op_ready;
  assign op       = q[rptr];

  // two entry queue toward the back end
  always_ff @(posedge clk) begin
    if (push) begin
      q[wptr] <= dec;
    end
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// File: sv/dkuc_back.sv
// Back end: word buffers, rebuild and diff sequencer, result register
`timescale 1ns / 1ps

module dkuc_back #(
  parameter int BUFFER_DEPTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         op_valid,
  output logic                         op_ready,
  input  dkuc_pkg::op_t                op,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [dkuc_pkg::TDATA_W-1:0] m_tdata,  // kind[1:0], code[17:2], zero pad
  output logic                         m_tlast,
  output logic                         m_tuser   // handled
);

  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam logic [AW-1:0] MAXC = AW'(BUFFER_DEPTH - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_BK_ADDR, S_BK_DATA, S_RB_ADDR, S_RB_DATA, S_RB_CALC, S_RB_PUT,
    S_DF_ADDR, S_DF_DATA, S_DF_END, S_FIN, S_SEND, S_SEND_DATA, S_MARK
  } state_t;

  state_t        state;
  logic [AW-1:0] tc;
  logic [AW-1:0] sc;
  logic          pend;
  logic          first;
  logic [15:0]   lastch;
  logic [AW-1:0] i;
  logic [AW-1:0] run;
  logic [AW-1:0] d3;
  logic [1:0]    m3;
  logic [15:0]   cur;
  logic [AW-1:0] cnt;
  logic [15:0]   put;
  logic [AW-1:0] len;
  logic [AW-1:0] common;
  logic [AW-1:0] er;
  logic [AW-1:0] chl;
  logic [AW-1:0] k;
  logic          pre;
  logic [15:0]   pre_code;
  logic          handled;
  logic [1:0]    out_kind;
  logic [15:0]   out_code;

  logic          can_push;
  logic          out_push;
  logic          ch_done;
  logic [AW-1:0] eff_tc;
  logic          app;
  logic          send_push;
  logic [15:0]   typed_rd;
  logic [15:0]   txt_rd;
  logic [15:0]   shown_rd;
  logic [AW-1:0] typed_ra;
  logic [AW-1:0] txt_ra;
  logic          typed_we;
  logic          txt_we;
  logic          shown_we;
  dkuc_pkg::rule_t rd_rule;
  dkuc_pkg::rule_t cur_rule;

  assign can_push = !m_tvalid || m_tready;
  assign op_ready = (state == S_IDLE);
  assign ch_done  = pend && (op.is_apos || (op.acute != 16'h0000));
  assign eff_tc   = pend ? '0 : tc;
  assign app      = (op.kind == dkuc_pkg::OP_CHAR) && !ch_done && op.is_letter && (eff_tc < MAXC);
  assign rd_rule  = dkuc_pkg::letter_rule(typed_rd);
  assign cur_rule = dkuc_pkg::letter_rule(cur);
  assign send_push = (state == S_SEND_DATA) && can_push;
  // a new result transaction is loaded this cycle
  assign out_push = can_push && ((state == S_MARK) || (state == S_SEND_DATA) ||
                                 ((state == S_SEND) && (pre || er != '0)));

  // memory port control
  always_comb begin
    typed_we = (state == S_IDLE) && op_valid && app;
    txt_we   = (state == S_RB_PUT) && (cnt != '0) && (len < MAXC);
    shown_we = send_push;
    typed_ra = (state == S_BK_ADDR || state == S_BK_DATA) ? tc - AW'(1) : i;
    if (state == S_SEND) begin
      txt_ra = k;
    end else if (state == S_SEND_DATA) begin
      txt_ra = send_push ? k + AW'(1) : k;
    end else begin
      txt_ra = common;
    end
  end

  dkuc_ram #(.WIDTH(16), .DEPTH(BUFFER_DEPTH)) u_typed (
    .clk(clk), .we(typed_we), .waddr(eff_tc), .wdata(op.ch), .raddr(typed_ra), .rdata(typed_rd)
  );

  dkuc_ram #(.WIDTH(16), .DEPTH(BUFFER_DEPTH)) u_txt (
    .clk(clk), .we(txt_we), .waddr(len), .wdata(put), .raddr(txt_ra), .rdata(txt_rd)
  );

  dkuc_ram #(.WIDTH(16), .DEPTH(BUFFER_DEPTH)) u_shown (
    .clk(clk), .we(shown_we), .waddr(k), .wdata(txt_rd), .raddr(common), .rdata(shown_rd)
  );

  assign m_tdata = {6'd0, out_code, out_kind};

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      tc       <= '0;
      sc       <= '0;
      pend     <= 1'b0;
      pre      <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && !out_push) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          i   <= '0;
          run <= '0;
          d3  <= '0;
          m3  <= 2'd0;
          len <= '0;
          er  <= '0;
          chl <= '0;
          if (op_valid) begin
            unique case (op.kind)
              dkuc_pkg::OP_BREAK: begin
                tc      <= '0;
                sc      <= '0;
                pend    <= 1'b0;
                handled <= 1'b0;
                state   <= S_FIN;
              end
              dkuc_pkg::OP_BKSP: begin
                if (pend) begin
                  pend    <= 1'b0;
                  handled <= 1'b1;
                  state   <= S_FIN;
                end else if (tc == '0) begin
                  handled <= 1'b0;
                  state   <= S_FIN;
                end else begin
                  handled <= 1'b1;
                  first   <= 1'b1;
                  state   <= S_BK_ADDR;
                end
              end
              dkuc_pkg::OP_CHAR: begin
                if (ch_done) begin
                  pend     <= 1'b0;
                  tc       <= '0;
                  sc       <= '0;
                  pre      <= 1'b1;
                  pre_code <= op.is_apos ? dkuc_pkg::APOSTROPHE : op.acute;
                  handled  <= 1'b1;
                  state    <= S_FIN;
                end else begin
                  pend <= op.is_apos;
                  if (pend) begin
                    pre      <= 1'b1;
                    pre_code <= dkuc_pkg::APOSTROPHE;
                  end
                  if (op.is_apos) begin
                    tc      <= '0;
                    sc      <= '0;
                    handled <= 1'b1;
                    state   <= S_FIN;
                  end else if (op.is_letter) begin
                    if (pend) begin
                      sc <= '0;
                    end
                    tc      <= app ? eff_tc + AW'(1) : eff_tc;
                    handled <= 1'b1;
                    state   <= S_RB_ADDR;
                  end else begin
                    tc      <= '0;
                    sc      <= '0;
                    handled <= 1'b0;
                    state   <= S_FIN;
                  end
                end
              end
              default: state <= S_FIN;
            endcase
          end
        end
        // strip the trailing letter or run of a rule letter
        S_BK_ADDR: state <= S_BK_DATA;
        S_BK_DATA: begin
          if (first || typed_rd == lastch) begin
            tc     <= tc - AW'(1);
            lastch <= typed_rd;
            first  <= 1'b0;
            if ((first && rd_rule.sp == 16'h0000) || tc == AW'(1)) begin
              state <= S_RB_ADDR;
            end else begin
              state <= S_BK_ADDR;
            end
          end else begin
            state <= S_RB_ADDR;
          end
        end
        // rebuild the shown text run by run
        S_RB_ADDR: begin
          if (i == tc) begin
            common <= '0;
            state  <= S_DF_ADDR;
          end else begin
            state <= S_RB_DATA;
          end
        end
        S_RB_DATA: begin
          if (run == '0 || typed_rd == cur) begin
            cur <= typed_rd;
            run <= run + AW'(1);
            m3  <= (m3 == 2'd2) ? 2'd0 : m3 + 2'd1;
            d3  <= d3 + AW'(m3 == 2'd2);
            i   <= i + AW'(1);
            state <= (i + AW'(1) == tc) ? S_RB_CALC : S_RB_ADDR;
          end else begin
            state <= S_RB_CALC;
          end
        end
        S_RB_CALC: begin
          if (cur_rule.sp == 16'h0000 || run < (cur_rule.trig3 ? AW'(3) : AW'(2))) begin
            cnt <= run;
            put <= cur;
          end else if (cur_rule.trig3 ? (m3 == 2'd0) : !run[0]) begin
            cnt <= cur_rule.trig3 ? d3 : (run >> 1);
            put <= cur_rule.sp;
          end else begin
            cnt <= run - AW'(1);
            put <= cur;
          end
          state <= S_RB_PUT;
        end
        S_RB_PUT: begin
          if (cnt != '0 && len < MAXC) begin
            len <= len + AW'(1);
            cnt <= cnt - AW'(1);
          end else begin
            run   <= '0;
            d3    <= '0;
            m3    <= 2'd0;
            state <= S_RB_ADDR;
          end
        end
        // common prefix of new and shown text
        S_DF_ADDR: begin
          state <= (common < sc && common < len) ? S_DF_DATA : S_DF_END;
        end
        S_DF_DATA: begin
          if (txt_rd == shown_rd) begin
            common <= common + AW'(1);
            state  <= S_DF_ADDR;
          end else begin
            state <= S_DF_END;
          end
        end
        S_DF_END: begin
          er    <= sc - common;
          chl   <= len - common;
          k     <= common;
          sc    <= len;
          state <= S_FIN;
        end
        S_FIN: begin
          state <= (pre || er != '0 || chl != '0) ? S_SEND : S_MARK;
        end
        S_MARK: begin
          if (can_push) begin
            m_tvalid <= 1'b1;
            out_kind <= dkuc_pkg::KIND_NONE;
            out_code <= 16'h0000;
            m_tlast  <= 1'b1;
            m_tuser  <= handled;
            state    <= S_IDLE;
          end
        end
        // emit pending apostrophe or accented letter, erases, then new characters
        S_SEND: begin
          if (pre) begin
            if (can_push) begin
              m_tvalid <= 1'b1;
              out_kind <= dkuc_pkg::KIND_EMIT;
              out_code <= pre_code;
              m_tlast  <= (er == '0 && chl == '0);
              m_tuser  <= handled && (er == '0 && chl == '0);
              pre      <= 1'b0;
              if (er == '0 && chl == '0) begin
                state <= S_IDLE;
              end
            end
          end else if (er != '0) begin
            if (can_push) begin
              m_tvalid <= 1'b1;
              out_kind <= dkuc_pkg::KIND_ERASE;
              out_code <= 16'h0000;
              m_tlast  <= (er == AW'(1) && chl == '0);
              m_tuser  <= handled && (er == AW'(1) && chl == '0);
              er       <= er - AW'(1);
              if (er == AW'(1) && chl == '0) begin
                state <= S_IDLE;
              end
            end
          end else if (chl != '0) begin
            state <= S_SEND_DATA;
          end else begin
            state <= S_IDLE;
          end
        end
        S_SEND_DATA: begin
          if (can_push) begin
            m_tvalid <= 1'b1;
            out_kind <= dkuc_pkg::KIND_EMIT;
            out_code <= txt_rd;
            m_tlast  <= (chl == AW'(1));
            m_tuser  <= handled && (chl == AW'(1));
            k        <= k + AW'(1);
            chl      <= chl - AW'(1);
            if (chl == AW'(1)) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // word never outgrows the buffer
  a_tc_max: assert property (@(posedge clk) disable iff (rst) tc <= MAXC)
    else $error("typed count above limit");
  a_sc_max: assert property (@(posedge clk) disable iff (rst) sc <= MAXC)
    else $error("shown count above limit");
  // dead key pending means the word was flushed
  a_pend_empty: assert property (@(posedge clk) disable iff (rst) pend |-> (tc == '0))
    else $error("dead key pending with letters held");
  // character emit state always has characters left
  a_send_left: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEND_DATA) |-> (chl != '0))
    else $error("character emit with nothing left");
  // no apostrophe left over once a key event is done
  a_pre_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !pre)
    else $error("pending apostrophe left in idle");

endmodule
